@@ src/page_slot_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// page_slot_allocator_macros
// Assertion macros shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef PAGE_SLOT_ALLOCATOR_MACROS_SVH
`define PAGE_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants of the page slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int DEF_MAX_PAGES = 64;
  localparam int DEF_MAX_SLOTS = 64;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

  localparam int ID_W = 6;

  typedef enum logic [1:0] {
    CMD_ADD_PAGE  = 2'd0,
    CMD_FIND_SLOT = 2'd1,
    CMD_ADD_ROW   = 2'd2,
    CMD_FIND_PAGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // latch request, read page entry
    logic execute;  // search, update, load result
  } ctl_t;

endpackage

@@ src/page_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// page_slot_allocator
// Row-slot occupancy tracker for a table of pages.
// ----------------------------------------------------------------------------
// Each request is handled in an accept step, the registered read of the page
// table memory entry addressed by page_id, then an execute step: the slot or
// page search, the write-back and the loading of the result register. A new
// request is taken once the previous one has executed, while its result may
// still wait in the output register; a request that finds the output register
// still full waits in execute until it drains. The page table memory is not
// cleared after reset: add page clears an entry before it can be addressed, so
// no clearing pass is needed and requests are taken right out of reset.
// ----------------------------------------------------------------------------
module page_slot_allocator #(
  parameter int MAX_PAGES = psa_pkg::DEF_MAX_PAGES,
  parameter int MAX_SLOTS = psa_pkg::DEF_MAX_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [psa_pkg::CFG_W-1:0] cfg_wr_data,   // slots_per_page
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,      // page_id[5:0], slot_index[11:6]
  input  logic [1:0]                in_tuser,      // cmd[1:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,     // index_out[5:0], page_now_full[6]
  output logic [1:0]                out_tuser      // status[1:0]
);

  psa_pkg::ctl_t ctl;

  psa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  psa_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .ctl         (ctl),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

@@ src/psa_ctrl.sv @@
// ----------------------------------------------------------------------------
// psa_ctrl
// Request sequencer: accept, execute, result handshake.
// ----------------------------------------------------------------------------
`include "page_slot_allocator_macros.svh"

module psa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output psa_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  assign ctl.accept  = in_tvalid && in_tready;
  assign ctl.execute = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PSA_ASSERT_NXT(a_accept_exec, ctl.accept, state_r == S_EXEC, "accept not followed by execute")
  `PSA_ASSERT_NXT(a_exec_hold, (state_r == S_EXEC) && out_valid_r && !out_tready, state_r == S_EXEC, "execute left with result pending")
  `PSA_ASSERT_NXT(a_exec_valid, ctl.execute, out_valid_r, "executed request produced no result")

endmodule

@@ src/psa_datapath.sv @@
// ----------------------------------------------------------------------------
// psa_datapath
// Page table memory, full marks, page counter, searches and result register.
// ----------------------------------------------------------------------------
`include "page_slot_allocator_macros.svh"

module psa_datapath #(
  parameter int MAX_PAGES = psa_pkg::DEF_MAX_PAGES,
  parameter int MAX_SLOTS = psa_pkg::DEF_MAX_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [psa_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic [15:0]              in_tdata,
  input  logic [1:0]               in_tuser,
  input  psa_pkg::ctl_t            ctl,
  output logic [7:0]               out_tdata,
  output logic [1:0]               out_tuser
);

  localparam int PAGE_CAP = (MAX_PAGES < 64) ? MAX_PAGES : 64;
  localparam int PAW      = (PAGE_CAP > 1) ? $clog2(PAGE_CAP) : 1;
  localparam int PCW      = $clog2(PAGE_CAP + 1);
  localparam int SW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW       = $clog2(MAX_SLOTS + 1);
  localparam int WW       = CW + MAX_SLOTS;
  localparam int IW       = psa_pkg::ID_W;
  localparam int NW       = psa_pkg::CFG_W;

  // config
  logic [NW-1:0] cfg_slots_r;
  logic [NW-1:0] eff_n;

  // request
  psa_pkg::cmd_t req_cmd_r;
  logic [IW-1:0] req_page_r;
  logic [IW-1:0] req_slot_r;

  // page entry: {used count, slot used bits}
  logic [WW-1:0] mem [PAGE_CAP];
  logic [WW-1:0] rd_word_r;
  logic [MAX_SLOTS-1:0] rd_bits;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] cnt_inc;

  logic [PAGE_CAP-1:0] page_full_r;
  logic [PCW-1:0]      pages_r;

  psa_pkg::status_t out_status_r;
  logic [IW-1:0]    out_index_r;
  logic             out_full_r;

  // search
  logic [PAGE_CAP-1:0] page_live;
  logic [PAGE_CAP-1:0] full_stray;
  logic                slot_found;
  logic [SW-1:0]       slot_free;
  logic                page_found;
  logic [PAW-1:0]      open_page;
  logic                page_ok, slot_ok, slot_hit, full_now;

  // execute
  psa_pkg::status_t res_status;
  logic [IW-1:0]    res_index;
  logic             res_full;
  logic             mem_we;
  logic [PAW-1:0]   mem_wa;
  logic [WW-1:0]    mem_wd;
  logic             pages_inc;
  logic             set_full, clr_full;
  logic [PAW-1:0]   full_idx;

  assign out_tdata = {1'b0, out_full_r, out_index_r};
  assign out_tuser = out_status_r;

  always_comb begin
    if (cfg_slots_r == '0) begin
      eff_n = NW'(1);
    end else if (cfg_slots_r > NW'(MAX_SLOTS)) begin
      eff_n = NW'(MAX_SLOTS);
    end else begin
      eff_n = cfg_slots_r;
    end
  end

  assign rd_bits = rd_word_r[MAX_SLOTS-1:0];
  assign rd_cnt  = rd_word_r[WW-1:MAX_SLOTS];
  assign cnt_inc = rd_cnt + CW'(1);

  assign page_ok  = {1'b0, req_page_r} < 7'(pages_r);
  assign slot_ok  = {1'b0, req_slot_r} < eff_n;
  assign slot_hit = slot_ok && rd_bits[req_slot_r[SW-1:0]];
  assign full_now = 7'(cnt_inc) >= eff_n;

  always_comb begin
    slot_found = 1'b0;
    slot_free  = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if ((7'(i) < eff_n) && !rd_bits[i]) begin
        slot_found = 1'b1;
        slot_free  = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PAGE_CAP; i++) begin
      page_live[i] = 7'(i) < 7'(pages_r);
    end
  end

  assign full_stray = page_full_r & ~page_live;

  always_comb begin
    page_found = 1'b0;
    open_page  = '0;
    for (int i = PAGE_CAP - 1; i >= 0; i--) begin
      if (page_live[i] && !page_full_r[i]) begin
        page_found = 1'b1;
        open_page  = PAW'(i);
      end
    end
  end

  always_comb begin
    res_status = psa_pkg::ST_OK;
    res_index  = '0;
    res_full   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = req_page_r[PAW-1:0];
    mem_wd     = rd_word_r;
    pages_inc  = 1'b0;
    set_full   = 1'b0;
    clr_full   = 1'b0;
    full_idx   = req_page_r[PAW-1:0];
    case (req_cmd_r)
      psa_pkg::CMD_ADD_PAGE: begin
        full_idx = pages_r[PAW-1:0];
        if (pages_r >= PCW'(PAGE_CAP)) begin
          res_status = psa_pkg::ST_NONE;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = pages_r[PAW-1:0];
          mem_wd    = '0;
          clr_full  = 1'b1;
          pages_inc = 1'b1;
          res_index = IW'(pages_r);
        end
      end
      psa_pkg::CMD_FIND_SLOT: begin
        if (!page_ok) begin
          res_status = psa_pkg::ST_BAD;
        end else if (slot_found) begin
          res_index = IW'(slot_free);
        end else begin
          res_status = psa_pkg::ST_NONE;
        end
      end
      psa_pkg::CMD_ADD_ROW: begin
        if (!page_ok || !slot_ok || slot_hit) begin
          res_status = psa_pkg::ST_BAD;
        end else begin
          mem_we = 1'b1;
          mem_wd = {cnt_inc, rd_bits | (MAX_SLOTS'(1) << req_slot_r[SW-1:0])};
          if (full_now) begin
            set_full = 1'b1;
            res_full = 1'b1;
          end
        end
      end
      psa_pkg::CMD_FIND_PAGE: begin
        if (page_found) begin
          res_index = IW'(open_page);
        end else begin
          res_status = psa_pkg::ST_NONE;
        end
      end
      default: res_status = psa_pkg::ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_slots_r <= psa_pkg::SLOTS_RESET;
    end else if (cfg_wr_en) begin
      cfg_slots_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_cmd_r  <= psa_pkg::cmd_t'(in_tuser);
      req_page_r <= in_tdata[5:0];
      req_slot_r <= in_tdata[11:6];
      rd_word_r  <= mem[in_tdata[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute && mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_full_r <= '0;
      pages_r     <= '0;
    end else if (ctl.execute) begin
      if (set_full) begin
        page_full_r[full_idx] <= 1'b1;
      end else if (clr_full) begin
        page_full_r[full_idx] <= 1'b0;
      end
      if (pages_inc) begin
        pages_r <= pages_r + PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_full_r   <= res_full;
    end
  end

  `PSA_ASSERT_IMP(a_pages_cap, 1'b1, pages_r <= PCW'(PAGE_CAP), "page count above capacity")
  `PSA_ASSERT_IMP(a_full_live, 1'b1, full_stray == '0, "full mark on a page not in use")
  `PSA_ASSERT_NXT(a_full_flag, ctl.execute && res_full, page_full_r[$past(full_idx)], "page full result without full mark")

endmodule

@@ tb/tb_page_slot_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_slot_allocator
// Self-checking bench for the page slot allocator: a directed pass over the
// bad page, bad slot, occupied slot and no-free cases, random command mixes
// under several slots-per-page settings, then a table-full run. Expected
// responses come from a behavioral table model updated on every accepted
// request. Both stream sides idle at random, and one long output stall is
// applied to back up the pipe.
// ----------------------------------------------------------------------------
module tb_page_slot_allocator;

  typedef struct {
    psa_pkg::cmd_t cmd;
    logic [5:0]    page_id;
    logic [5:0]    slot_index;
  } slot_req_t;

  typedef struct {
    psa_pkg::status_t status;
    logic [5:0]       index_out;
    logic             now_full;
  } slot_rsp_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  page_slot_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // page_id[5:0], slot_index[11:6]
    .in_tuser   (in_tuser),     // cmd[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // index_out[5:0], page_now_full[6]
    .out_tuser  (out_tuser)     // status[1:0]
  );

  always #1 clk = ~clk;

  // table model
  bit [63:0] slot_map [64];
  bit [6:0]  used_cnt [64];
  bit [63:0] full_map;
  int        pages_used;
  bit [6:0]  slots_cfg;

  slot_req_t pending_reqs[$];
  slot_rsp_t expected_rsps[$];
  slot_req_t cur_req;
  int        planned_pages;
  int        accepted_reqs;
  int        error_count;
  int        cycle_cnt;
  int        hold_left;
  bit        hold_done;
  bit        calm;

  function automatic int eff_slots(bit [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic slot_rsp_t apply_table_cmd(slot_req_t r);
    slot_rsp_t rsp;
    int n;
    int pg;
    n = eff_slots(slots_cfg);
    pg = r.page_id;
    rsp.status = psa_pkg::ST_OK;
    rsp.index_out = '0;
    rsp.now_full = 1'b0;
    case (r.cmd)
      psa_pkg::CMD_ADD_PAGE: begin
        if (pages_used >= 64) begin
          rsp.status = psa_pkg::ST_NONE;
        end else begin
          slot_map[pages_used] = '0;
          used_cnt[pages_used] = '0;
          full_map[pages_used] = 1'b0;
          rsp.index_out = pages_used[5:0];
          pages_used++;
        end
      end
      psa_pkg::CMD_FIND_SLOT: begin
        if (pg >= pages_used) begin
          rsp.status = psa_pkg::ST_BAD;
        end else begin
          rsp.status = psa_pkg::ST_NONE;
          for (int i = 0; i < n; i++) begin
            if (!slot_map[pg][i]) begin
              rsp.status = psa_pkg::ST_OK;
              rsp.index_out = i[5:0];
              break;
            end
          end
        end
      end
      psa_pkg::CMD_ADD_ROW: begin
        if (pg >= pages_used || r.slot_index >= n || slot_map[pg][r.slot_index]) begin
          rsp.status = psa_pkg::ST_BAD;
        end else begin
          slot_map[pg][r.slot_index] = 1'b1;
          used_cnt[pg] = used_cnt[pg] + 7'd1;
          if (used_cnt[pg] >= n) begin
            full_map[pg] = 1'b1;
            rsp.now_full = 1'b1;
          end
        end
      end
      default: begin
        rsp.status = psa_pkg::ST_NONE;
        for (int i = 0; i < pages_used; i++) begin
          if (!full_map[i]) begin
            rsp.status = psa_pkg::ST_OK;
            rsp.index_out = i[5:0];
            break;
          end
        end
      end
    endcase
    return rsp;
  endfunction

  task automatic push_req(psa_pkg::cmd_t c, int pg, int sl);
    slot_req_t r;
    r.cmd = c;
    r.page_id = pg[5:0];
    r.slot_index = sl[5:0];
    if (c == psa_pkg::CMD_ADD_PAGE && planned_pages < 64) planned_pages++;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_random_reqs(int count, int n);
    int roll;
    int lo;
    int pg;
    int sl;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      lo = (planned_pages > 3) ? planned_pages - 3 : 0;
      if (planned_pages == 0) pg = 0;
      else if ($urandom_range(0, 9) < 6) pg = $urandom_range(lo, planned_pages - 1);
      else pg = $urandom_range(0, planned_pages - 1);
      sl = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
      if (roll < 5) push_req(psa_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 63));
      else if (roll < 13) push_req(psa_pkg::CMD_ADD_PAGE, $urandom_range(0, 63),
                                   $urandom_range(0, 63));
      else if (roll < 38) push_req(psa_pkg::CMD_FIND_SLOT, pg, $urandom_range(0, 63));
      else if (roll < 88) push_req(psa_pkg::CMD_ADD_ROW, pg, sl);
      else push_req(psa_pkg::CMD_FIND_PAGE, $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slots_per_page(bit [6:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    slots_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    calm <= (cycle_cnt % 3000) >= 2200;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(apply_table_cmd(cur_req));
        accepted_reqs++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, cur_req.slot_index, cur_req.page_id};
          in_tuser <= cur_req.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // response side ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && accepted_reqs >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // response monitor
  always @(posedge clk) begin
    slot_rsp_t exp_rsp;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rsps.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected response status=%0d index=%0d full=%0b",
                   out_tuser, out_tdata[5:0], out_tdata[6]);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_tuser !== exp_rsp.status || out_tdata[5:0] !== exp_rsp.index_out ||
            out_tdata[6] !== exp_rsp.now_full || out_tdata[7] !== 1'b0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: status exp %0d got %0d, index exp %0d got %0d, full exp %0b got %0b",
                     exp_rsp.status, out_tuser, exp_rsp.index_out, out_tdata[5:0],
                     exp_rsp.now_full, out_tdata[6]);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    bit [6:0] cfg_list [9] = '{7'd1, 7'd127, 7'd64, 7'd5, 7'd2, 7'd17, 7'd33, 7'd100, 7'd8};
    full_map = '0;
    pages_used = 0;
    slots_cfg = psa_pkg::SLOTS_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, bad page/slot, occupied slot, fill, no free page
    set_slots_per_page(7'd3);
    push_req(psa_pkg::CMD_FIND_PAGE, 0, 0);
    push_req(psa_pkg::CMD_FIND_SLOT, 0, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 0);
    push_req(psa_pkg::CMD_ADD_PAGE, 63, 63);
    push_req(psa_pkg::CMD_ADD_PAGE, 0, 0);
    push_req(psa_pkg::CMD_FIND_SLOT, 0, 63);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 3);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 63);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 0);
    push_req(psa_pkg::CMD_FIND_SLOT, 0, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 2);
    push_req(psa_pkg::CMD_ADD_ROW, 0, 1);
    push_req(psa_pkg::CMD_FIND_SLOT, 0, 0);
    push_req(psa_pkg::CMD_FIND_PAGE, 63, 63);
    push_req(psa_pkg::CMD_ADD_ROW, 63, 0);
    push_req(psa_pkg::CMD_FIND_SLOT, 63, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 1, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 1, 1);
    push_req(psa_pkg::CMD_ADD_ROW, 1, 2);
    push_req(psa_pkg::CMD_FIND_PAGE, 0, 0);
    drain();

    // zero slot count acts as one
    set_slots_per_page(7'd0);
    push_req(psa_pkg::CMD_ADD_PAGE, 0, 0);
    push_req(psa_pkg::CMD_ADD_ROW, 2, 1);
    push_req(psa_pkg::CMD_ADD_ROW, 2, 0);
    push_req(psa_pkg::CMD_FIND_SLOT, 2, 0);
    push_req(psa_pkg::CMD_FIND_PAGE, 0, 0);
    drain();

    foreach (cfg_list[k]) begin
      set_slots_per_page(cfg_list[k]);
      queue_random_reqs(95, eff_slots(cfg_list[k]));
      drain();
    end

    // run the table out of pages
    set_slots_per_page(7'd64);
    for (int k = 0; k < 70; k++) push_req(psa_pkg::CMD_ADD_PAGE, $urandom_range(0, 63), 0);
    push_req(psa_pkg::CMD_FIND_PAGE, 0, 0);
    queue_random_reqs(40, 64);
    drain();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/psa_pkg.sv
src/psa_ctrl.sv
src/psa_datapath.sv
src/page_slot_allocator.sv
tb/tb_page_slot_allocator.sv
